// File: rtl/two_channel_frame_deframer_defines.svh
// Assertion macros for the two-channel frame deframer.
`ifndef TWO_CHANNEL_FRAME_DEFRAMER_DEFINES_SVH
`define TWO_CHANNEL_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define DFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define DFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define DFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dfr_pkg.sv
// Shared types and constants for the two-channel frame deframer.
package dfr_pkg;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CHAN = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOHEAD   = 2'd1;
    localparam logic [1:0] ST_NOSELECT = 2'd2;

    localparam logic [1:0] CFG_HEAD_BYTE       = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_BIT     = 2'd1;
    localparam logic [1:0] CFG_HUNT_LIMIT      = 2'd2;
    localparam logic [1:0] CFG_SELECT_ATTEMPTS = 2'd3;

    localparam logic [7:0] RST_HEAD_BYTE       = 8'h55;
    localparam logic [2:0] RST_CHANNEL_BIT     = 3'd5;
    localparam logic [3:0] RST_HUNT_LIMIT      = 4'd5;
    localparam logic [1:0] RST_SELECT_ATTEMPTS = 2'd2;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [2:0] channel_bit;
        logic [3:0] hunt_limit;
        logic [1:0] select_attempts;
    } t_cfg;

    typedef struct packed {
        logic [15:0] red_value;
        logic [15:0] blue_value;
        logic [1:0]  status;
    } t_result;

endpackage

// File: rtl/dfr_cfg.sv
// Configuration register file of the deframer.
module dfr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output dfr_pkg::t_cfg o_cfg
);
    import dfr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte       <= RST_HEAD_BYTE;
            r_cfg.channel_bit     <= RST_CHANNEL_BIT;
            r_cfg.hunt_limit      <= RST_HUNT_LIMIT;
            r_cfg.select_attempts <= RST_SELECT_ATTEMPTS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEAD_BYTE:       r_cfg.head_byte       <= i_cfg_data;
                CFG_CHANNEL_BIT:     r_cfg.channel_bit     <= i_cfg_data[2:0];
                CFG_HUNT_LIMIT:      r_cfg.hunt_limit      <= i_cfg_data[3:0];
                CFG_SELECT_ATTEMPTS: r_cfg.select_attempts <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dfr_core.sv
// Frame state machine: hunt, channel check and word assembly per byte.
module dfr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dfr_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output dfr_pkg::t_result o_res
);
    import dfr_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_hunt_count, n_hunt_count;
    logic [1:0]  r_attempt_count, n_attempt_count;
    logic        r_exp_chan, n_exp_chan;
    logic [7:0]  r_low_byte, n_low_byte;
    logic [15:0] r_first_word, n_first_word;

    logic [3:0]  hunt_inc;
    logic [1:0]  attempt_inc;
    logic        chan_bit;

    assign hunt_inc    = r_hunt_count + 4'd1;
    assign attempt_inc = r_attempt_count + 2'd1;
    assign chan_bit    = i_byte[i_cfg.channel_bit];

    always_comb begin
        n_phase         = r_phase;
        n_hunt_count    = r_hunt_count;
        n_attempt_count = r_attempt_count;
        n_exp_chan      = r_exp_chan;
        n_low_byte      = r_low_byte;
        n_first_word    = r_first_word;
        o_res_valid     = 1'b0;
        o_res           = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.head_byte) begin
                    n_phase = PH_CHAN;
                end else if (hunt_inc >= i_cfg.hunt_limit || hunt_inc == 4'd0) begin
                    n_phase         = PH_HUNT;
                    n_hunt_count    = 4'd0;
                    n_attempt_count = 2'd0;
                    n_exp_chan      = 1'b0;
                    o_res_valid     = 1'b1;
                    o_res.status    = ST_NOHEAD;
                end else begin
                    n_hunt_count = hunt_inc;
                end
            end
            PH_CHAN: begin
                if (chan_bit == r_exp_chan) begin
                    n_attempt_count = 2'd0;
                    n_phase         = PH_LOW;
                end else if (attempt_inc >= i_cfg.select_attempts || attempt_inc == 2'd0) begin
                    n_phase         = PH_HUNT;
                    n_hunt_count    = 4'd0;
                    n_attempt_count = 2'd0;
                    n_exp_chan      = 1'b0;
                    o_res_valid     = 1'b1;
                    o_res.status    = ST_NOSELECT;
                end else begin
                    n_attempt_count = attempt_inc;
                    n_hunt_count    = 4'd0;
                    n_phase         = PH_HUNT;
                end
            end
            PH_LOW: begin
                n_low_byte = i_byte;
                n_phase    = PH_HIGH;
            end
            PH_HIGH: begin
                n_phase         = PH_HUNT;
                n_hunt_count    = 4'd0;
                n_attempt_count = 2'd0;
                if (!r_exp_chan) begin
                    n_first_word = {i_byte, r_low_byte};
                    n_exp_chan   = 1'b1;
                end else begin
                    n_exp_chan       = 1'b0;
                    o_res_valid      = 1'b1;
                    o_res.red_value  = r_first_word;
                    o_res.blue_value = {i_byte, r_low_byte};
                    o_res.status     = ST_OK;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_hunt_count    <= 4'd0;
            r_attempt_count <= 2'd0;
            r_exp_chan      <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_hunt_count    <= n_hunt_count;
            r_attempt_count <= n_attempt_count;
            r_exp_chan      <= n_exp_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_low_byte   <= n_low_byte;
            r_first_word <= n_first_word;
        end
    end

endmodule

// File: rtl/two_channel_frame_deframer.sv
// Two-channel frame deframer top level: input register, frame core, result register.
// Each byte goes input register, frame core, then result register, which drives the outputs.
// Throughput: one byte per cycle; the input register frees whenever the result register can load.
// Results that wait under stall hold the result register; the input register still takes one byte.
// Reset (synchronous, active low) restores register defaults, hunts for channel 0, empties both
// registers.
`include "two_channel_frame_deframer_defines.svh"
module two_channel_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [15:0] o_red_value,
    output logic [15:0] o_blue_value,
    output logic [1:0]  o_status,
    input  logic        i_out_stall
);
    import dfr_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic out_ready;
    logic step;
    logic in_ready;
    logic in_accept;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign step      = r_in_valid && out_ready;
    assign in_ready  = !r_in_valid || step;
    assign in_accept = i_in_valid && in_ready;

    dfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall   = !in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_red_value  = r_out.red_value;
    assign o_blue_value = r_out.blue_value;
    assign o_status     = r_out.status;

    `DFR_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    `DFR_ASSERT_IMP(a_error_zero_words, i_clk, i_rst_n, o_out_valid && o_status != ST_OK,
                    o_red_value == 16'd0 && o_blue_value == 16'd0)
    `DFR_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, step && res_valid, o_out_valid)

endmodule

// File: verif/dfr_frame_check.sv
// Checker for the two-channel frame deframer: tracks register writes, predicts and compares results.
module dfr_frame_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  logic [15:0] i_red_value,
    input  logic [15:0] i_blue_value,
    input  logic [1:0]  i_status,
    input  logic        i_out_stall,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_ok_count,
    output int          o_nohead_count,
    output int          o_noselect_count
);
    import dfr_pkg::*;

    t_cfg        regs;
    logic [1:0]  phase;
    logic [3:0]  hunt_cnt;
    logic [1:0]  miss_cnt;
    logic        chan_sel;
    logic [7:0]  low_byte;
    logic [15:0] red_word;
    t_result     expected_frames[$];
    int          fails;
    int          n_ok;
    int          n_nohead;
    int          n_noselect;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic restart_hunt();
        phase    = PH_HUNT;
        hunt_cnt = 4'd0;
        miss_cnt = 2'd0;
        chan_sel = 1'b0;
    endtask

    task automatic push_frame(input logic [15:0] red, input logic [15:0] blue,
                              input logic [1:0] st);
        t_result r;
        r.red_value  = red;
        r.blue_value = blue;
        r.status     = st;
        expected_frames.push_back(r);
        case (st)
            ST_OK:       n_ok++;
            ST_NOHEAD:   n_nohead++;
            default:     n_noselect++;
        endcase
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (phase)
            PH_HUNT: begin
                if (b == regs.head_byte) begin
                    phase = PH_CHAN;
                end else begin
                    hunt_cnt = hunt_cnt + 4'd1;
                    if (hunt_cnt >= regs.hunt_limit || hunt_cnt == 4'd0) begin
                        restart_hunt();
                        push_frame(16'h0000, 16'h0000, ST_NOHEAD);
                    end
                end
            end
            PH_CHAN: begin
                if (b[regs.channel_bit] == chan_sel) begin
                    miss_cnt = 2'd0;
                    phase    = PH_LOW;
                end else begin
                    miss_cnt = miss_cnt + 2'd1;
                    if (miss_cnt >= regs.select_attempts || miss_cnt == 2'd0) begin
                        restart_hunt();
                        push_frame(16'h0000, 16'h0000, ST_NOSELECT);
                    end else begin
                        // retry: fresh hunt for the same channel
                        hunt_cnt = 4'd0;
                        phase    = PH_HUNT;
                    end
                end
            end
            PH_LOW: begin
                low_byte = b;
                phase    = PH_HIGH;
            end
            default: begin
                if (!chan_sel) begin
                    red_word = {b, low_byte};
                    chan_sel = 1'b1;
                    hunt_cnt = 4'd0;
                    miss_cnt = 2'd0;
                    phase    = PH_HUNT;
                end else begin
                    restart_hunt();
                    push_frame(red_word, {b, low_byte}, ST_OK);
                end
            end
        endcase
    endtask

    task automatic check_frame();
        t_result want;
        if (expected_frames.size() == 0) begin
            report_mismatch("result with none expected, status", i_status, 0);
        end else begin
            want = expected_frames.pop_front();
            if (i_red_value !== want.red_value)
                report_mismatch("red_value", i_red_value, want.red_value);
            if (i_blue_value !== want.blue_value)
                report_mismatch("blue_value", i_blue_value, want.blue_value);
            if (i_status !== want.status)
                report_mismatch("status", i_status, want.status);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.head_byte       = RST_HEAD_BYTE;
            regs.channel_bit     = RST_CHANNEL_BIT;
            regs.hunt_limit      = RST_HUNT_LIMIT;
            regs.select_attempts = RST_SELECT_ATTEMPTS;
            restart_hunt();
            low_byte = 8'h00;
            red_word = 16'h0000;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAD_BYTE:   regs.head_byte   = i_cfg_data;
                    CFG_CHANNEL_BIT: regs.channel_bit = i_cfg_data[2:0];
                    CFG_HUNT_LIMIT:  regs.hunt_limit  = i_cfg_data[3:0];
                    default:         regs.select_attempts = i_cfg_data[1:0];
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_frame();
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_rx_byte);
        end
        o_fail_count     <= fails;
        o_pending        <= expected_frames.size();
        o_ok_count       <= n_ok;
        o_nohead_count   <= n_nohead;
        o_noselect_count <= n_noselect;
    end

endmodule

// File: verif/tb_top.sv
// Top-level testbench for the two-channel frame deframer: clock, reset, stimulus and verdict.
module tb_top;
    import dfr_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENT_ITEMS  = 105;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic [7:0]  i_rx_byte;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_red_value;
    logic [15:0] o_blue_value;
    logic [1:0]  o_status;
    logic        i_out_stall;

    int fail_count;
    int pending;
    int ok_count;
    int nohead_count;
    int noselect_count;

    logic [7:0] cur_head;
    logic [2:0] cur_chan_bit;
    logic [3:0] cur_limit;
    logic [1:0] cur_tries;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_seq;
    int         n_sent;
    int         n_settings;
    int         stuck_cycles;

    two_channel_frame_deframer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_red_value  (o_red_value),
        .o_blue_value (o_blue_value),
        .o_status     (o_status),
        .i_out_stall  (i_out_stall)
    );

    dfr_frame_check frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_rx_byte        (i_rx_byte),
        .i_in_stall       (o_in_stall),
        .i_out_valid      (o_out_valid),
        .i_red_value      (o_red_value),
        .i_blue_value     (o_blue_value),
        .i_status         (o_status),
        .i_out_stall      (i_out_stall),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_ok_count       (ok_count),
        .o_nohead_count   (nohead_count),
        .o_noselect_count (noselect_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output side: random stall, plus one long hold each time hold_seq moves
    initial begin : rx_side
        int ack;
        ack = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != ack) begin
                ack = hold_seq;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // stuck_cycles at WATCHDOG_LIMIT, with no transfer, cfg write or reset, means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we || !i_rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic logic [7:0] non_head_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == cur_head) b = ~b;
        return b;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        logic [7:0] mask;
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        case (idx)
            CFG_HEAD_BYTE:   mask = 8'hFF;
            CFG_CHANNEL_BIT: mask = 8'h07;
            CFG_HUNT_LIMIT:  mask = 8'h0F;
            default:         mask = 8'h03;
        endcase
        // unused upper bits carry noise now and then
        if ($urandom_range(0, 3) != 0) junk = 8'h00;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= (val & mask) | (junk & ~mask);
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] head, input logic [2:0] chan_bit,
                            input logic [3:0] limit, input logic [1:0] tries);
        put_reg(CFG_HEAD_BYTE, head);
        put_reg(CFG_CHANNEL_BIT, {5'd0, chan_bit});
        put_reg(CFG_HUNT_LIMIT, {4'd0, limit});
        put_reg(CFG_SELECT_ATTEMPTS, {6'd0, tries});
        i_cfg_we     <= 1'b0;
        cur_head     = head;
        cur_chan_bit = chan_bit;
        cur_limit    = limit;
        cur_tries    = tries;
        n_settings++;
    endtask

    task automatic set_random_regs();
        set_regs(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    endtask

    // mostly a short hunt, a head, a channel byte and two data bytes; wrong channel retries
    task automatic send_channel(input logic ch);
        int         gap;
        logic       wrong;
        logic [7:0] sel;
        do begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(0, 15);
            else
                gap = $urandom_range(0, (cur_limit == 4'd0) ? 0 : cur_limit - 1);
            repeat (gap) send_byte(non_head_byte());
            send_byte(cur_head);
            wrong = ($urandom_range(0, 7) == 0);
            sel   = 8'($urandom_range(0, 255));
            sel[cur_chan_bit] = ch ^ wrong;
            send_byte(sel);
        end while (wrong);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_traffic(input int n_items);
        int start;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_channel(1'b0);
                send_channel(1'b1);
            end
        end
        drain();
    endtask

    initial begin : stimulus
        logic [7:0] directed[$];
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_HEAD_BYTE;
        i_cfg_data    <= 8'h00;
        i_in_valid    <= 1'b0;
        i_rx_byte     <= 8'h00;
        recv_idle_pct <= 0;
        hold_seq      <= 0;
        send_idle_pct = 0;
        n_sent        = 0;
        n_settings    = 1;
        cur_head      = RST_HEAD_BYTE;
        cur_chan_bit  = RST_CHANNEL_BIT;
        cur_limit     = RST_HUNT_LIMIT;
        cur_tries     = RST_SELECT_ATTEMPTS;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: retry then good frame, select failure, hunt failure
        directed = '{8'h55, 8'hFF, 8'h55, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'h20, 8'h00, 8'h00,
                     8'h55, 8'hFF, 8'h55, 8'h20,
                     8'h11, 8'h22, 8'h33, 8'h44, 8'h66};
        foreach (directed[k]) send_byte(directed[k]);
        drain();
        // zero hunt limit and zero attempts act as one
        set_regs(8'h55, 3'd5, 4'd0, 2'd0);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hFF);
        drain();

        send_idle_pct = 18;
        recv_idle_pct <= 75;
        set_regs(8'h00, 3'd0, 4'd15, 2'd3);
        run_traffic(SEGMENT_ITEMS);
        set_regs(8'hFF, 3'd7, 4'd1, 2'd1);
        run_traffic(SEGMENT_ITEMS);

        send_idle_pct = 75;
        recv_idle_pct <= 18;
        set_random_regs();
        run_traffic(SEGMENT_ITEMS);
        set_random_regs();
        run_traffic(SEGMENT_ITEMS);

        // back-pressure: every non-head byte fails the hunt while the output is held
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_regs(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 4'd1,
                 2'($urandom_range(0, 3)));
        hold_seq <= hold_seq + 1;
        repeat (30) send_byte(non_head_byte());
        drain();
        set_regs(8'h55, 3'd5, 4'd5, 2'd2);
        run_traffic(SEGMENT_ITEMS);
        set_random_regs();
        run_traffic(SEGMENT_ITEMS);

        $display("Covered %0d bytes over %0d register settings, three stall mixes and a long hold.",
                 n_sent, n_settings);
        $display("Results: %0d frames ok, %0d head-byte misses, %0d channel-select failures.",
                 ok_count, nohead_count, noselect_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
